// ----- hw/rtl/base32_stream_codec_defines.svh -----
// assertion macros shared by the base32 codec rtl
`ifndef BASE32_STREAM_CODEC_DEFINES_SVH
`define BASE32_STREAM_CODEC_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define B32_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("base32 codec check failed");

// next-cycle implication, checked on clk, off during reset
`define B32_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("base32 codec check failed");

`endif

// ----- hw/rtl/b32_pkg.sv -----
// types, constants and symbol helpers for the base32 codec
package b32_pkg;

	localparam int unsigned B32_QUEUE_DEPTH = 2;
	localparam int unsigned B32_MAX_RESULTS = 3;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic REG_DIRECTION = 1'b0;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_ILLEGAL = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_TWO     = 8'h32;
	localparam logic [7:0] CH_SEVEN   = 8'h37;
	localparam logic [7:0] CH_HYPHEN  = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	typedef struct packed {
		logic [7:0] in_value;
		logic       in_last;
	} b32_in_t;

	typedef struct packed {
		logic [7:0] out_value;
		logic       out_valid;
		logic       out_last;
		logic [1:0] out_status;
	} b32_out_t;

	// one accepted word's worth of results, count is 0..3 (only 1..3 is pushed)
	typedef struct packed {
		logic [1:0]                       count;
		b32_out_t [B32_MAX_RESULTS-1:0]   item;
	} b32_job_t;

	// 5-bit group to its ascii symbol
	function automatic logic [7:0] symbol_of(input logic [4:0] v);
		logic [7:0] r;
		if (v < 5'd26) begin
			r = CH_UPPER_A + {3'd0, v};
		end else begin
			r = CH_TWO + {3'd0, v - 5'd26};
		end
		return r;
	endfunction

	// ascii char to 0..31, bit 5 set when not a symbol
	function automatic logic [5:0] value_of(input logic [7:0] c);
		logic [7:0] u;
		logic [5:0] r;
		u = c;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			u = c - 8'h20;
		end
		if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
			r = {1'b0, 5'(u - CH_UPPER_A)};
		end else if (u >= CH_TWO && u <= CH_SEVEN) begin
			r = {1'b0, 5'(u - CH_TWO + 8'd26)};
		end else begin
			r = 6'b100000;
		end
		return r;
	endfunction

	// low n bits set
	function automatic logic [11:0] mask12(input logic [3:0] n);
		return (12'd1 << n) - 12'd1;
	endfunction

endpackage

// ----- hw/rtl/b32_front.sv -----
// front: takes words, tracks message state, builds result jobs
module b32_front import b32_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     direction,
	input  logic     clear,
	input  logic     accept,
	input  b32_in_t  data,
	output logic     push,
	output b32_job_t job
);

	logic [11:0] buf_q;
	logic [3:0]  cnt_q;
	logic        content_q, symbol_q, pend_q, err_q;

	logic [11:0] buf_n;
	logic [3:0]  cnt_n;
	logic        content_n, symbol_n, pend_n, err_n;

	// encode path
	logic [11:0] e_buf1, e_buf2, e_buf3;
	logic [3:0]  e_c1, e_c2, e_c3;
	logic        e_two, e_pad;
	logic [7:0]  e_sym0, e_sym1, e_sympad;

	// decode path
	logic        d_space, d_ws;
	logic [5:0]  d_val;
	logic [11:0] d_buf;
	logic [3:0]  d_cnt;
	logic        d_emit;
	logic [7:0]  d_byte;
	logic [1:0]  d_status;

	always_comb begin
		e_buf1  = {buf_q[3:0], data.in_value};
		e_c1    = cnt_q + 4'd8;
		e_c2    = e_c1 - 4'd5;
		e_sym0  = symbol_of(5'(e_buf1 >> e_c2));
		e_buf2  = e_buf1 & mask12(e_c2);
		e_two   = (e_c2 >= 4'd5);
		e_c3    = e_two ? e_c2 - 4'd5 : e_c2;
		e_sym1  = symbol_of(5'(e_buf2 >> e_c3));
		e_buf3  = e_two ? (e_buf2 & mask12(e_c3)) : e_buf2;
		e_pad   = data.in_last && (e_c3 != 4'd0);
		e_sympad = symbol_of(5'(e_buf3 << (4'd5 - e_c3)));
	end

	always_comb begin
		d_space   = (data.in_value == CH_SPACE);
		d_ws      = (data.in_value >= CH_TAB) && (data.in_value <= CH_CR);
		d_val     = value_of(data.in_value);
		d_buf     = buf_q;
		d_cnt     = cnt_q;
		d_emit    = 1'b0;
		d_byte    = 8'd0;
		content_n = content_q;
		symbol_n  = symbol_q;
		pend_n    = pend_q;
		err_n     = err_q;
		if (d_space) begin
			// spaces vanish anywhere
		end else if (d_ws) begin
			if (content_q) begin
				pend_n = 1'b1;
			end
		end else begin
			content_n = 1'b1;
			if (pend_q) begin
				err_n = 1'b1;
			end else if (data.in_value != CH_HYPHEN && !err_q) begin
				if (d_val[5]) begin
					err_n = 1'b1;
				end else begin
					symbol_n = 1'b1;
					d_buf    = {buf_q[6:0], d_val[4:0]};
					d_cnt    = cnt_q + 4'd5;
					if (d_cnt >= 4'd8) begin
						d_emit = 1'b1;
						d_byte = 8'(d_buf >> (d_cnt - 4'd8));
						d_cnt  = d_cnt - 4'd8;
						d_buf  = d_buf & mask12(d_cnt);
					end
				end
			end
		end
		if (err_n) begin
			d_status = STATUS_ILLEGAL;
		end else if (symbol_n) begin
			d_status = STATUS_OK;
		end else begin
			d_status = STATUS_EMPTY;
		end
	end

	always_comb begin
		job   = '0;
		buf_n = buf_q;
		cnt_n = cnt_q;
		if (direction == DIR_ENCODE) begin
			job.item[0] = '{out_value: e_sym0, out_valid: 1'b1, out_last: 1'b0,
				out_status: STATUS_OK};
			if (e_two) begin
				job.item[1] = '{out_value: e_sym1, out_valid: 1'b1, out_last: 1'b0,
					out_status: STATUS_OK};
			end
			if (e_pad) begin
				job.item[e_two ? 2'd2 : 2'd1] = '{out_value: e_sympad, out_valid: 1'b1,
					out_last: 1'b0, out_status: STATUS_OK};
			end
			job.count = 2'd1 + {1'b0, e_two} + {1'b0, e_pad};
			if (data.in_last) begin
				job.item[job.count - 2'd1].out_last = 1'b1;
			end
			buf_n = e_buf3;
			cnt_n = e_c3;
		end else begin
			if (d_emit) begin
				job.item[0] = '{out_value: d_byte, out_valid: 1'b1, out_last: 1'b0,
					out_status: STATUS_OK};
			end
			if (data.in_last) begin
				job.item[d_emit ? 2'd1 : 2'd0] = '{out_value: 8'd0, out_valid: 1'b0,
					out_last: 1'b1, out_status: d_status};
			end
			job.count = {1'b0, d_emit} + {1'b0, data.in_last};
			buf_n = d_buf;
			cnt_n = d_cnt;
		end
	end

	assign push = accept && (job.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q     <= '0;
			cnt_q     <= '0;
			content_q <= 1'b0;
			symbol_q  <= 1'b0;
			pend_q    <= 1'b0;
			err_q     <= 1'b0;
		end else if (clear || (accept && data.in_last)) begin
			buf_q     <= '0;
			cnt_q     <= '0;
			content_q <= 1'b0;
			symbol_q  <= 1'b0;
			pend_q    <= 1'b0;
			err_q     <= 1'b0;
		end else if (accept) begin
			buf_q <= buf_n;
			cnt_q <= cnt_n;
			if (direction == DIR_DECODE) begin
				content_q <= content_n;
				symbol_q  <= symbol_n;
				pend_q    <= pend_n;
				err_q     <= err_n;
			end
		end
	end

endmodule

// ----- hw/rtl/b32_queue.sv -----
// job queue between front and back
module b32_queue import b32_pkg::*; #(
	parameter int unsigned DEPTH = B32_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  b32_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     nonempty,
	output b32_job_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b32_job_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == FULL_CNT);
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/b32_back.sv -----
// back: unrolls jobs into result words through an output register
module b32_back import b32_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_nonempty,
	input  b32_job_t q_head,
	output logic     q_pop,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output b32_out_t rsp_data
);

	b32_job_t   job_q;
	logic       job_valid_q;
	logic [1:0] idx_q;
	logic       rsp_valid_q;
	b32_out_t   rsp_data_q;

	logic out_free, emit, job_done;

	assign out_free = !rsp_valid_q || rsp_ready;
	assign emit     = job_valid_q && out_free;
	assign job_done = emit && ((idx_q + 2'd1) == job_q.count);
	assign q_pop    = q_nonempty && (!job_valid_q || job_done);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			rsp_data_q <= job_q.item[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (job_done) begin
				job_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 2'd1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

// ----- hw/rtl/base32_stream_codec.sv -----
// top level of the streaming base32 codec
//
// usage
//  - req channel (req_valid/req_ready/req_data) takes one word per message
//    item: a byte when encoding, an ascii char when decoding; in_last ends it
//  - rsp channel (rsp_valid/rsp_ready/rsp_data) returns result words: symbols
//    when encoding, bytes plus one closing status word when decoding
//  - apb port, register 0 at address 0: direction, 0 encode, 1 decode;
//    writing it clears any partial message, write only while idle
//  - path: result words pass through the job queue, the job register, then the output register
//  - throughput: one result word per cycle while rsp_ready holds, set by the output register;
//    encode averages 1.6 words per byte (two words per byte at worst,
//    three on the last byte of a message), decode takes a char every cycle while the queue has room
//  - the front classifies each word and queues a job of one to three result
//    words when it yields any; the back drains jobs, so the front keeps taking
//    input while the output stalls until the job queue fills
//  - reset: direction goes to encode, queue empty, message state cleared
//  - receiver stall: the output word holds, jobs back up, then req_ready drops
`include "base32_stream_codec_defines.svh"

module base32_stream_codec import b32_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = B32_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        req_valid,
	output logic        req_ready,
	input  b32_in_t     req_data,
	// result words
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output b32_out_t    rsp_data,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic     dir_q;
	logic     cfg_wr;
	logic     accept;
	logic     push;
	b32_job_t front_job;
	logic     q_full, q_nonempty, q_pop;
	b32_job_t q_head;

	// register index is paddr[2]; only index 0 exists
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
	assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, dir_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
		end else if (cfg_wr) begin
			dir_q <= pwdata[0];
		end
	end

	// input is taken whenever the job queue has room
	assign req_ready = !q_full;
	assign accept    = req_valid && req_ready;

	b32_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.direction (dir_q),
		.clear     (cfg_wr),
		.accept    (accept),
		.data      (req_data),
		.push      (push),
		.job       (front_job)
	);

	b32_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (front_job),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	b32_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_data   (rsp_data)
	);

	// a status-only word always closes its message
	`B32_ASSERT_NOW(a_status_word_last, rsp_valid && !rsp_data.out_valid, rsp_data.out_last)
	// encoding never produces a status-only word
	`B32_ASSERT_NOW(a_encode_has_data, rsp_valid && (dir_q == DIR_ENCODE), rsp_data.out_valid)
	// a nonzero status only rides on the closing word
	`B32_ASSERT_NOW(a_status_on_last, rsp_valid && (rsp_data.out_status != STATUS_OK),
		rsp_data.out_last)
	// a job pushed into an empty queue with no result word showing leaves the queue or output busy in the next cycle
	`B32_ASSERT_NEXT(a_job_drains, push && !q_nonempty && !rsp_valid, q_nonempty || rsp_valid)

endmodule
